@@ src/sptl_pkg.sv @@
// Shared types, constants and a helper function for the segmented priority trie lookup.
`default_nettype none

package sptl_pkg;

    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;
    localparam int HOP_W  = 8;
    localparam int VIS_W  = 5;

    // Longest legal prefix; longer insert lengths saturate here.
    localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

    // Transaction kinds carried on the input tuser bit.
    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEG,
        ST_ROOT,
        ST_NODE,
        ST_MAKE,
        ST_MARK,
        ST_DONE
    } state_t;

    // Fixed-width part of one trie node.
    typedef struct packed {
        logic             prio;
        logic [HOP_W-1:0] hop;
        logic [LEN_W-1:0] len;
        logic [ADDR_W-1:0] prefix;
    } node_info_t;

    // Results of the shared prefix compare unit.
    typedef struct packed {
        logic match;
        logic dup;
        logic nest;
    } cmp_t;

    // Network mask for a prefix length; zero length gives an empty mask.
    function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        return ~({ADDR_W{1'b1}} >> len);
    endfunction

endpackage

`default_nettype wire

@@ src/sptl_seg_mem.sv @@
// Segment mark and segment root memories with registered read.
`default_nettype none

module sptl_seg_mem
    import sptl_pkg::*;
#(
    parameter int SEG_W = 16,
    parameter int PTR_W = 17
) (
    input  wire logic             aclk,
    input  wire logic             rd_en,
    input  wire logic [SEG_W-1:0] rd_addr,
    output logic                  rd_mark,
    output logic [PTR_W-1:0]      rd_root,
    input  wire logic [SEG_W-1:0] wr_addr,
    input  wire logic             mark_we,
    input  wire logic             mark_d,
    input  wire logic             root_we,
    input  wire logic [PTR_W-1:0] root_d
);

    logic             mark_mem [2**SEG_W];
    logic [PTR_W-1:0] root_mem [2**SEG_W];

    // Write ports share one address.
    always_ff @(posedge aclk) begin
        if (mark_we) begin
            mark_mem[wr_addr] <= mark_d;
        end
        if (root_we) begin
            root_mem[wr_addr] <= root_d;
        end
    end

    // Registered read of both stores at one segment.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_mark <= mark_mem[rd_addr];
            rd_root <= root_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ src/sptl_node_mem.sv @@
// Trie node memory: prefix, length, next hop, priority flag and child pointers.
`default_nettype none

module sptl_node_mem
    import sptl_pkg::*;
#(
    parameter int DEPTH = 65536,
    parameter int IDX_W = 16,
    parameter int PTR_W = 17
) (
    input  wire logic             aclk,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output node_info_t            rd_info,
    output logic [PTR_W-1:0]      rd_left,
    output logic [PTR_W-1:0]      rd_right,
    input  wire logic             we,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire node_info_t       wr_info,
    input  wire logic [PTR_W-1:0] wr_left,
    input  wire logic [PTR_W-1:0] wr_right
);

    node_info_t       info_mem  [DEPTH];
    logic [PTR_W-1:0] left_mem  [DEPTH];
    logic [PTR_W-1:0] right_mem [DEPTH];

    // A node is always written in full.
    always_ff @(posedge aclk) begin
        if (we) begin
            info_mem[wr_addr]  <= wr_info;
            left_mem[wr_addr]  <= wr_left;
            right_mem[wr_addr] <= wr_right;
        end
    end

    // Registered read of one node.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_info  <= info_mem[rd_addr];
            rd_left  <= left_mem[rd_addr];
            rd_right <= right_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ src/sptl_cmp.sv @@
// Shared prefix compare unit used by both the lookup and the insert walk.
`default_nettype none

module sptl_cmp
    import sptl_pkg::*;
(
    input  wire logic [ADDR_W-1:0] node_prefix,
    input  wire logic [LEN_W-1:0]  node_len,
    input  wire logic [ADDR_W-1:0] q_addr,
    input  wire logic [LEN_W-1:0]  q_len,
    output cmp_t                   res
);

    logic [ADDR_W-1:0] node_mask;
    logic [ADDR_W-1:0] q_mask;
    logic [ADDR_W-1:0] node_up;
    logic [ADDR_W-1:0] q_up;

    assign node_mask = len_mask(node_len);
    assign q_mask    = len_mask(q_len);
    assign node_up   = node_prefix | ~node_mask;
    assign q_up      = q_addr | ~q_mask;

    // Address covered by the node, identical prefix, and strict nesting.
    always_comb begin
        res.match = ((q_addr ^ node_prefix) & node_mask) == '0;
        res.dup   = (node_prefix == q_addr) && (node_len == q_len);
        res.nest  = (q_len > node_len) && (node_prefix <= q_addr) && (node_up >= q_up);
    end

endmodule

`default_nettype wire

@@ src/segmented_priority_trie_lookup.sv @@
// Top level: sequencer for segmented priority trie inserts and lookups.
`default_nettype none

// One transaction is handled at a time, and the next is taken while a result
// still waits on the output. A lookup reads at most 33 - SEGMENT_BITS trie
// nodes; the node memory read port walks one node per cycle. A prefix of
// SEGMENT_BITS or fewer bits writes 2^(SEGMENT_BITS - length) segment marks,
// one per cycle. A longer prefix walks the trie twice, first to check for a
// duplicate or lack of room and then to commit, and then writes the new node.
// After reset the block clears all 2^SEGMENT_BITS segments of the mark and
// root stores, one segment per cycle, before it takes its first transaction.
module segmented_priority_trie_lookup
    import sptl_pkg::*;
#(
    parameter int SEGMENT_BITS = 16,
    parameter int NODE_COUNT   = 65536
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // address[31:0], prefix_len[37:32], next_hop[45:38]
    input  wire logic [0:0]  s_tuser,   // kind[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // hit[0], short_hit[1], trie_hit[2], hop_out[10:3],
                                        // nodes_visited[15:11], table_full[16]
);

    localparam int SEG_W = SEGMENT_BITS;
    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam int PTR_W = IDX_W + 1;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [LEN_W-1:0]  in_len_reg, in_len_next;
    logic [HOP_W-1:0]  in_hop_reg, in_hop_next;
    logic              kind_reg, kind_next;
    logic              commit_reg, commit_next;
    logic [ADDR_W-1:0] low_reg, low_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [HOP_W-1:0]  hop_reg, hop_next;
    logic [LEN_W-1:0]  level_reg, level_next;
    logic [IDX_W-1:0]  node_reg, node_next;
    logic [SEG_W-1:0]  idx_reg, idx_next;
    logic [SEG_W-1:0]  span_reg, span_next;
    logic [PTR_W-1:0]  used_reg, used_next;
    logic              short_reg, short_next;
    logic              trie_reg, trie_next;
    logic [HOP_W-1:0]  hop_out_reg, hop_out_next;
    logic [VIS_W-1:0]  visited_reg, visited_next;
    logic              full_reg, full_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              out_short_reg, out_short_next;
    logic              out_trie_reg, out_trie_next;
    logic [HOP_W-1:0]  out_hop_reg, out_hop_next;
    logic [VIS_W-1:0]  out_visited_reg, out_visited_next;
    logic              out_full_reg, out_full_next;

    // Input payload fields.
    logic [ADDR_W-1:0] s_addr;
    logic [LEN_W-1:0]  s_len;
    logic [LEN_W-1:0]  s_len_sat;
    logic [HOP_W-1:0]  s_hop;
    logic              s_accept;

    assign s_addr    = s_tdata[31:0];
    assign s_len     = s_tdata[37:32];
    assign s_hop     = s_tdata[45:38];
    assign s_len_sat = (s_len > MAX_LEN) ? MAX_LEN : s_len;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;

    // Memory ports.
    logic             seg_rd_en;
    logic [SEG_W-1:0] seg_rd_addr;
    logic             seg_mark;
    logic [PTR_W-1:0] seg_root;
    logic [SEG_W-1:0] seg_wr_addr;
    logic             mark_we;
    logic             mark_d;
    logic             root_we;
    logic [PTR_W-1:0] root_d;

    logic             nd_rd_en;
    logic [IDX_W-1:0] nd_rd_addr;
    node_info_t       nd_info;
    logic [PTR_W-1:0] nd_left;
    logic [PTR_W-1:0] nd_right;
    logic             nd_we;
    logic [IDX_W-1:0] nd_wr_addr;
    node_info_t       nd_wr_info;
    logic [PTR_W-1:0] nd_wr_left;
    logic [PTR_W-1:0] nd_wr_right;

    sptl_seg_mem #(
        .SEG_W (SEG_W),
        .PTR_W (PTR_W)
    ) u_seg_mem (
        .aclk    (aclk),
        .rd_en   (seg_rd_en),
        .rd_addr (seg_rd_addr),
        .rd_mark (seg_mark),
        .rd_root (seg_root),
        .wr_addr (seg_wr_addr),
        .mark_we (mark_we),
        .mark_d  (mark_d),
        .root_we (root_we),
        .root_d  (root_d)
    );

    sptl_node_mem #(
        .DEPTH (NODE_COUNT),
        .IDX_W (IDX_W),
        .PTR_W (PTR_W)
    ) u_node_mem (
        .aclk     (aclk),
        .rd_en    (nd_rd_en),
        .rd_addr  (nd_rd_addr),
        .rd_info  (nd_info),
        .rd_left  (nd_left),
        .rd_right (nd_right),
        .we       (nd_we),
        .wr_addr  (nd_wr_addr),
        .wr_info  (nd_wr_info),
        .wr_left  (nd_wr_left),
        .wr_right (nd_wr_right)
    );

    // Shared compare: lookups test the raw address, inserts the carried prefix.
    cmp_t              cmp;
    logic [ADDR_W-1:0] q_addr;

    assign q_addr = (kind_reg == KIND_INSERT) ? low_reg : addr_reg;

    sptl_cmp u_cmp (
        .node_prefix (nd_info.prefix),
        .node_len    (nd_info.len),
        .q_addr      (q_addr),
        .q_len       (len_reg),
        .res         (cmp)
    );

    // Per-node decisions of the walk.
    logic              root_null;
    logic              pool_full;
    logic              at_end;
    logic              swap;
    logic [ADDR_W-1:0] post_low;
    logic [LEN_W-1:0]  post_len;
    logic [HOP_W-1:0]  post_hop;
    logic [4:0]        bit_sel;
    logic              dir;
    logic [PTR_W-1:0]  child;
    logic              child_null;
    logic [PTR_W-1:0]  new_ptr;
    logic              out_free;
    logic [ADDR_W-1:0] in_low;

    assign root_null  = (seg_root == '0);
    assign pool_full  = (used_reg == PTR_W'(NODE_COUNT));
    assign at_end     = (level_reg >= MAX_LEN);
    assign swap       = nd_info.prio && ((len_reg == level_reg) || cmp.nest);
    assign post_low   = swap ? nd_info.prefix : low_reg;
    assign post_len   = swap ? nd_info.len : len_reg;
    assign post_hop   = swap ? nd_info.hop : hop_reg;
    assign bit_sel    = 5'(MAX_LEN - 6'd1 - level_reg);
    assign dir        = (kind_reg == KIND_INSERT) ? post_low[bit_sel] : addr_reg[bit_sel];
    assign child      = dir ? nd_right : nd_left;
    assign child_null = (child == '0);
    assign new_ptr    = used_reg + 1'b1;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign in_low     = addr_reg & len_mask(in_len_reg);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (idx_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser[0] == KIND_INSERT && s_len_sat <= LEN_W'(SEGMENT_BITS)) begin
                        state_next = ST_MARK;
                    end else begin
                        state_next = ST_SEG;
                    end
                end
            end
            ST_SEG: begin
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (!root_null) begin
                    state_next = ST_NODE;
                end else if (kind_reg == KIND_LOOKUP || pool_full || commit_reg) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_SEG;
                end
            end
            ST_NODE: begin
                if (kind_reg == KIND_LOOKUP) begin
                    if ((cmp.match && nd_info.prio) || at_end || child_null) begin
                        state_next = ST_DONE;
                    end
                end else if (cmp.dup || at_end) begin
                    state_next = ST_DONE;
                end else if (child_null) begin
                    if (pool_full) begin
                        state_next = ST_DONE;
                    end else if (commit_reg) begin
                        state_next = ST_MAKE;
                    end else begin
                        state_next = ST_SEG;
                    end
                end
            end
            ST_MAKE: begin
                state_next = ST_DONE;
            end
            ST_MARK: begin
                if ((idx_reg & span_reg) == span_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Datapath, memory controls and result registers.
    always_comb begin
        addr_next        = addr_reg;
        in_len_next      = in_len_reg;
        in_hop_next      = in_hop_reg;
        kind_next        = kind_reg;
        commit_next      = commit_reg;
        low_next         = low_reg;
        len_next         = len_reg;
        hop_next         = hop_reg;
        level_next       = level_reg;
        node_next        = node_reg;
        idx_next         = idx_reg;
        span_next        = span_reg;
        used_next        = used_reg;
        short_next       = short_reg;
        trie_next        = trie_reg;
        hop_out_next     = hop_out_reg;
        visited_next     = visited_reg;
        full_next        = full_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        out_short_next   = out_short_reg;
        out_trie_next    = out_trie_reg;
        out_hop_next     = out_hop_reg;
        out_visited_next = out_visited_reg;
        out_full_next    = out_full_reg;

        seg_rd_en   = 1'b0;
        seg_rd_addr = addr_reg[ADDR_W-1 -: SEG_W];
        seg_wr_addr = addr_reg[ADDR_W-1 -: SEG_W];
        mark_we     = 1'b0;
        mark_d      = 1'b1;
        root_we     = 1'b0;
        root_d      = new_ptr;
        nd_rd_en    = 1'b0;
        nd_rd_addr  = IDX_W'(child - 1'b1);
        nd_we       = 1'b0;
        nd_wr_addr  = node_reg;
        nd_wr_info  = nd_info;
        nd_wr_left  = nd_left;
        nd_wr_right = nd_right;

        unique case (state_reg)
            ST_CLEAR: begin
                // Clear one segment of marks and roots per cycle.
                seg_wr_addr = idx_reg;
                mark_we     = 1'b1;
                mark_d      = 1'b0;
                root_we     = 1'b1;
                root_d      = '0;
                idx_next    = idx_reg + 1'b1;
            end
            ST_IDLE: begin
                if (s_accept) begin
                    addr_next    = s_addr;
                    in_len_next  = s_len_sat;
                    in_hop_next  = s_hop;
                    kind_next    = s_tuser[0];
                    commit_next  = 1'b0;
                    low_next     = s_addr & len_mask(s_len_sat);
                    len_next     = s_len_sat;
                    hop_next     = s_hop;
                    level_next   = LEN_W'(SEGMENT_BITS);
                    span_next    = SEG_W'({SEG_W{1'b1}} >> s_len_sat);
                    idx_next     = s_addr[ADDR_W-1 -: SEG_W]
                                   & ~SEG_W'({SEG_W{1'b1}} >> s_len_sat);
                    short_next   = 1'b0;
                    trie_next    = 1'b0;
                    hop_out_next = '0;
                    visited_next = '0;
                    full_next    = 1'b0;
                end
            end
            ST_SEG: begin
                seg_rd_en = 1'b1;
            end
            ST_ROOT: begin
                if (kind_reg == KIND_LOOKUP) begin
                    short_next = seg_mark;
                end
                if (!root_null) begin
                    nd_rd_en   = 1'b1;
                    nd_rd_addr = IDX_W'(seg_root - 1'b1);
                    node_next  = IDX_W'(seg_root - 1'b1);
                end else if (kind_reg == KIND_INSERT) begin
                    if (pool_full) begin
                        full_next = 1'b1;
                    end else if (commit_reg) begin
                        // First node of this segment's trie.
                        root_we         = 1'b1;
                        nd_we           = 1'b1;
                        nd_wr_addr      = IDX_W'(used_reg);
                        nd_wr_info      = '{prio: len_reg > level_reg, hop: hop_reg,
                                            len: len_reg, prefix: low_reg};
                        nd_wr_left      = '0;
                        nd_wr_right     = '0;
                        used_next       = new_ptr;
                    end else begin
                        commit_next = 1'b1;
                    end
                end
            end
            ST_NODE: begin
                if (kind_reg == KIND_LOOKUP) begin
                    visited_next = visited_reg + 1'b1;
                    if (cmp.match) begin
                        trie_next    = 1'b1;
                        hop_out_next = nd_info.hop;
                    end
                    if (!((cmp.match && nd_info.prio) || at_end || child_null)) begin
                        nd_rd_en   = 1'b1;
                        node_next  = IDX_W'(child - 1'b1);
                        level_next = level_reg + 1'b1;
                    end
                end else if (cmp.dup) begin
                    full_next = 1'b0;
                end else if (at_end) begin
                    full_next = 1'b1;
                end else begin
                    low_next = post_low;
                    len_next = post_len;
                    hop_next = post_hop;
                    if (swap) begin
                        nd_wr_info = '{prio: len_reg != level_reg, hop: hop_reg,
                                       len: len_reg, prefix: low_reg};
                    end
                    if (child_null) begin
                        if (pool_full) begin
                            full_next = 1'b1;
                        end else if (commit_reg) begin
                            // Hang the new node under this one, then write it.
                            nd_we = 1'b1;
                            if (dir) begin
                                nd_wr_right = new_ptr;
                            end else begin
                                nd_wr_left = new_ptr;
                            end
                        end else begin
                            commit_next = 1'b1;
                        end
                    end else begin
                        nd_we      = commit_reg && swap;
                        nd_rd_en   = 1'b1;
                        node_next  = IDX_W'(child - 1'b1);
                        level_next = level_reg + 1'b1;
                    end
                end
            end
            ST_MAKE: begin
                nd_we       = 1'b1;
                nd_wr_addr  = IDX_W'(used_reg);
                nd_wr_info  = '{prio: len_reg > (level_reg + 1'b1), hop: hop_reg,
                                len: len_reg, prefix: low_reg};
                nd_wr_left  = '0;
                nd_wr_right = '0;
                used_next   = new_ptr;
            end
            ST_MARK: begin
                seg_wr_addr = idx_reg;
                mark_we     = 1'b1;
                idx_next    = idx_reg + 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next    = 1'b1;
                    out_short_next   = short_reg;
                    out_trie_next    = trie_reg;
                    out_hop_next     = hop_out_reg;
                    out_visited_next = visited_reg;
                    out_full_next    = full_reg;
                end
            end
            default: begin
                idx_next = '0;
            end
        endcase

        // A restart of the walk for the commit pass reloads the carried prefix.
        if (state_next == ST_SEG && state_reg != ST_IDLE) begin
            low_next   = in_low;
            len_next   = in_len_reg;
            hop_next   = in_hop_reg;
            level_next = LEN_W'(SEGMENT_BITS);
        end
    end

    // Registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            idx_reg      <= '0;
            used_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            used_reg     <= used_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg        <= addr_next;
        in_len_reg      <= in_len_next;
        in_hop_reg      <= in_hop_next;
        kind_reg        <= kind_next;
        commit_reg      <= commit_next;
        low_reg         <= low_next;
        len_reg         <= len_next;
        hop_reg         <= hop_next;
        level_reg       <= level_next;
        node_reg        <= node_next;
        span_reg        <= span_next;
        short_reg       <= short_next;
        trie_reg        <= trie_next;
        hop_out_reg     <= hop_out_next;
        visited_reg     <= visited_next;
        full_reg        <= full_next;
        out_short_reg   <= out_short_next;
        out_trie_reg    <= out_trie_next;
        out_hop_reg     <= out_hop_next;
        out_visited_reg <= out_visited_next;
        out_full_reg    <= out_full_next;
    end

    // Output packing.
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_full_reg, out_visited_reg, out_hop_reg,
                       out_trie_reg, out_short_reg, out_short_reg | out_trie_reg};

`ifndef SYNTHESIS
    a_pool_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= PTR_W'(NODE_COUNT))
        else $error("node pool count beyond its size");

    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_tready)
        else $error("input taken during the clearing pass");

    a_pool_step: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (used_reg == $past(used_reg)) || (used_reg == $past(used_reg) + 1'b1))
        else $error("node pool count moved by more than one");

    a_full_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && out_full_reg |-> !out_short_reg && !out_trie_reg)
        else $error("dropped insert reports a lookup hit");
`endif

endmodule

`default_nettype wire

@@ bench/sptl_checker.sv @@
// Checker for the segmented priority trie lookup: predicts each result and compares it.
`timescale 1ns / 1ps

module sptl_checker
    import sptl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,
    input  wire logic [0:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,
    output int               errors,
    output int               pending,
    output int               trie_hits
);

    localparam int SEG_BITS  = 16;
    localparam int SEG_CNT   = 1 << SEG_BITS;
    localparam int NODE_MAX  = 65536;

    // Outcome of placing one trie prefix.
    typedef enum int {PLACED, DUPLICATE, NO_ROOM} place_t;

    // One result as it appears on the result channel.
    typedef struct packed {
        logic             full;
        logic [VIS_W-1:0] visited;
        logic [HOP_W-1:0] hop;
        logic             trie;
        logic             short_m;
        logic             hit;
    } answer_t;

    // Shadow copy of the table.
    bit                seg_mark [SEG_CNT];
    int                seg_root [SEG_CNT];
    logic [ADDR_W-1:0] nd_prefix [NODE_MAX];
    int                nd_len [NODE_MAX];
    logic [HOP_W-1:0]  nd_hop [NODE_MAX];
    bit                nd_prio [NODE_MAX];
    int                nd_left [NODE_MAX];
    int                nd_right [NODE_MAX];
    int                nodes_used;

    answer_t           answers_due [$];

    function automatic logic [31:0] net_mask(int len);
        if (len == 0) return 32'h0;
        return 32'hFFFF_FFFF << (32 - len);
    endfunction

    function automatic int grab_node(logic [31:0] low, int len, logic [7:0] hop, bit prio);
        int n;
        n = nodes_used;
        nodes_used++;
        nd_prefix[n] = low;
        nd_len[n]    = len;
        nd_hop[n]    = hop;
        nd_prio[n]   = prio;
        nd_left[n]   = 0;
        nd_right[n]  = 0;
        return n + 1;
    endfunction

    // Walks the segment's trie; writes only when commit is set.
    function automatic place_t trie_place(int seg, logic [31:0] low, int len,
                                          logic [7:0] hop, bit commit);
        int          cur;
        int          level;
        int          n;
        int          child;
        int          made;
        int          olen;
        logic [31:0] olow;
        logic [7:0]  ohop;
        logic [31:0] up;
        logic [31:0] nup;
        bit          go_right;
        cur   = seg_root[seg];
        level = SEG_BITS;
        if (cur == 0) begin
            if (nodes_used >= NODE_MAX) return NO_ROOM;
            if (commit) seg_root[seg] = grab_node(low, len, hop, len > level);
            return PLACED;
        end
        forever begin
            n    = cur - 1;
            olow = nd_prefix[n];
            olen = nd_len[n];
            up   = low | ~net_mask(len);
            nup  = olow | ~net_mask(olen);
            if (olow == low && olen == len) return DUPLICATE;
            // A priority node yields to a level-length or longer nested prefix.
            if (nd_prio[n] && (len == level || (len > olen && olow <= low && nup >= up))) begin
                ohop = nd_hop[n];
                if (commit) begin
                    nd_prefix[n] = low;
                    nd_len[n]    = len;
                    nd_hop[n]    = hop;
                    nd_prio[n]   = (len != level);
                end
                low = olow;
                len = olen;
                hop = ohop;
            end
            if (level >= 32) return NO_ROOM;
            go_right = low[31 - level];
            child = go_right ? nd_right[n] : nd_left[n];
            if (child == 0) begin
                if (nodes_used >= NODE_MAX) return NO_ROOM;
                if (commit) begin
                    made = grab_node(low, len, hop, len > level + 1);
                    if (go_right) nd_right[n] = made;
                    else nd_left[n] = made;
                end
                return PLACED;
            end
            cur = child;
            level++;
        end
    endfunction

    // Expected result of one accepted transaction; updates the shadow table.
    function automatic answer_t predict_answer(logic kind, logic [31:0] addr,
                                               logic [5:0] plen, logic [7:0] hop);
        answer_t     a;
        int          len;
        int          seg;
        int          cnt;
        int          start;
        int          cur;
        int          level;
        int          n;
        logic [31:0] low;
        a   = '0;
        seg = addr >> (32 - SEG_BITS);
        if (kind == KIND_INSERT) begin
            len = (plen > MAX_LEN) ? 32 : int'(plen);
            low = addr & net_mask(len);
            seg = low >> (32 - SEG_BITS);
            if (len <= SEG_BITS) begin
                cnt   = 1 << (SEG_BITS - len);
                start = seg & ~(cnt - 1);
                for (int i = 0; i < cnt; i++) seg_mark[(start + i) % SEG_CNT] = 1'b1;
            end else begin
                case (trie_place(seg, low, len, hop, 1'b0))
                    PLACED:  void'(trie_place(seg, low, len, hop, 1'b1));
                    NO_ROOM: a.full = 1'b1;
                    default: ;
                endcase
            end
        end else begin
            cur       = seg_root[seg];
            level     = SEG_BITS;
            a.short_m = seg_mark[seg];
            while (cur != 0) begin
                n = cur - 1;
                a.visited++;
                if (((addr ^ nd_prefix[n]) & net_mask(nd_len[n])) == 0) begin
                    a.trie = 1'b1;
                    a.hop  = nd_hop[n];
                    if (nd_prio[n]) break;
                end
                if (level >= 32) break;
                cur = addr[31 - level] ? nd_right[n] : nd_left[n];
                level++;
            end
            a.hit = a.short_m | a.trie;
        end
        return a;
    endfunction

    assign pending = answers_due.size();

    initial begin
        errors    = 0;
        trie_hits = 0;
        nodes_used = 0;
    end

    // Predict on input transactions, compare on result transactions.
    always @(posedge aclk) begin
        answer_t want;
        answer_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                answers_due.push_back(predict_answer(s_tuser[0], s_tdata[31:0],
                                                     s_tdata[37:32], s_tdata[45:38]));
            if (m_tvalid && m_tready) begin
                got = m_tdata[16:0];
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    errors++;
                end else begin
                    want = answers_due.pop_front();
                    if (want.trie) trie_hits++;
                    if (got.hit !== want.hit) begin
                        $display("%0t: hit expected %b actual %b", $time, want.hit, got.hit);
                        errors++;
                    end
                    if (got.short_m !== want.short_m) begin
                        $display("%0t: short_hit expected %b actual %b",
                                 $time, want.short_m, got.short_m);
                        errors++;
                    end
                    if (got.trie !== want.trie) begin
                        $display("%0t: trie_hit expected %b actual %b", $time, want.trie, got.trie);
                        errors++;
                    end
                    if (got.hop !== want.hop) begin
                        $display("%0t: hop_out expected %0d actual %0d", $time, want.hop, got.hop);
                        errors++;
                    end
                    if (got.visited !== want.visited) begin
                        $display("%0t: nodes_visited expected %0d actual %0d",
                                 $time, want.visited, got.visited);
                        errors++;
                    end
                    if (got.full !== want.full) begin
                        $display("%0t: table_full expected %b actual %b",
                                 $time, want.full, got.full);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

@@ bench/testbench.sv @@
// Testbench top: clock, reset, stimulus and verdict for the segmented priority trie lookup.
`timescale 1ns / 1ps

module testbench
    import sptl_pkg::*;
;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;    // address[31:0], prefix_len[37:32], next_hop[45:38]
    logic [0:0]  s_tuser;    // kind[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // hit[0], short_hit[1], trie_hit[2], hop_out[10:3],
                             // nodes_visited[15:11], table_full[16]
    int          errors;
    int          pending;
    int          trie_hits;
    int          lookups_sent;
    int          inserts_sent;
    bit          no_gaps;
    int          seg_pool [8];

    segmented_priority_trie_lookup dut (.*);

    sptl_checker u_checker (.*);

    // 8 ns clock; it starts low so the first rising edge comes after reset is driven.
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Sends one transaction after a random gap and waits until it is accepted.
    task automatic send_item(logic kind, logic [31:0] addr, logic [5:0] plen, logic [7:0] hop);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, hop, plen, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (kind == KIND_INSERT) inserts_sent++;
        else lookups_sent++;
    endtask

    // Address, mostly inside one of a few busy segments, often with sparse low bits.
    function automatic logic [31:0] pick_addr();
        logic [15:0] lo_mask;
        if ($urandom_range(0, 9) == 0) return $urandom;
        case ($urandom_range(0, 3))
            0: lo_mask = 16'hFFFF;
            1: lo_mask = 16'hF00F;
            2: lo_mask = 16'h000F;
            default: lo_mask = 16'h8103;
        endcase
        return {seg_pool[$urandom_range(0, 7)][15:0], 16'($urandom) & lo_mask};
    endfunction

    // Result side: a random stall before each result, with calm stretches.
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Run limit.
    initial begin
        #40ms;
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        int          r;
        logic [5:0]  plen;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = KIND_LOOKUP;
        aresetn      = 1'b0;
        no_gaps      = 1'b0;
        lookups_sent = 0;
        inserts_sent = 0;
        seg_pool[0]  = 0;
        seg_pool[1]  = 16'hFFFF;
        for (int i = 2; i < 8; i++) seg_pool[i] = $urandom_range(0, 16'hFFFF);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty table, extreme addresses, short prefixes.
        send_item(KIND_LOOKUP, 32'h0000_0000, 6'd0, 8'd0);
        send_item(KIND_LOOKUP, 32'hFFFF_FFFF, 6'd63, 8'hFF);
        send_item(KIND_INSERT, 32'hFFFF_FFFF, 6'd16, 8'hFF);
        send_item(KIND_INSERT, 32'h8000_0000, 6'd1, 8'h00);
        send_item(KIND_LOOKUP, 32'hC123_4567, 6'd0, 8'd0);
        // Over-long length saturates; host bits of a short length are cleared.
        send_item(KIND_INSERT, 32'h0000_1234, 6'd63, 8'hA5);
        send_item(KIND_INSERT, 32'h0000_12FF, 6'd24, 8'h5A);
        send_item(KIND_INSERT, 32'h0000_12FF, 6'd24, 8'h11);  // duplicate
        send_item(KIND_INSERT, 32'h0000_0000, 6'd17, 8'h01);
        send_item(KIND_LOOKUP, 32'h0000_1234, 6'd0, 8'd0);
        send_item(KIND_LOOKUP, 32'h0000_12AA, 6'd0, 8'd0);
        // A chain of host routes in one segment runs down to level 31 of the trie.
        for (int i = 0; i < 18; i++)
            send_item(KIND_INSERT, 32'h00AB_0000 | i, 6'd32, 8'(i));
        send_item(KIND_LOOKUP, 32'h00AB_0011, 6'd0, 8'd0);

        // Random part; the sender holds off now and then until all results are in.
        for (int k = 0; k < 1700; k++) begin
            if (k % 150 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            if (k % 400 == 200) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                wait (pending == 0);
            end
            if ($urandom_range(0, 1)) begin
                r = $urandom_range(0, 9);
                if (r < 7) plen = 6'($urandom_range(17, 32));
                else if (r < 8) plen = 6'($urandom_range(33, 63));
                else plen = 6'($urandom_range(10, 16));
                send_item(KIND_INSERT, pick_addr(), plen, 8'($urandom));
            end else begin
                send_item(KIND_LOOKUP, pick_addr(), 6'($urandom), 8'($urandom));
            end
        end

        // A zero-length prefix marks every segment, so it comes last.
        send_item(KIND_INSERT, $urandom, 6'd0, 8'($urandom));
        send_item(KIND_LOOKUP, $urandom, 6'd0, 8'd0);
        send_item(KIND_LOOKUP, pick_addr(), 6'd0, 8'd0);
        s_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (100) @(posedge aclk);
        $display("Ran %0d lookups and %0d inserts; %0d lookups matched a trie prefix.",
                 lookups_sent, inserts_sent, trie_hits);
        if (errors == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/sptl_pkg.sv
src/sptl_seg_mem.sv
src/sptl_node_mem.sv
src/sptl_cmp.sv
src/segmented_priority_trie_lookup.sv
bench/sptl_checker.sv
bench/testbench.sv
